### src/hte_pkg.sv
`timescale 1ns / 1ps

package hte_pkg;

	typedef enum logic [2:0] {
		MODE_TEXT    = 3'd0,
		MODE_OPEN    = 3'd1,
		MODE_TAG     = 3'd2,
		MODE_COMMENT = 3'd3,
		MODE_SCRIPT  = 3'd4,
		MODE_STYLE   = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		SEP_NONE    = 2'd0,
		SEP_SPACE   = 2'd1,
		SEP_NEWLINE = 2'd2
	} sep_t;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;

	localparam logic [3:0] COMMENT_LEN      = 4'd3;
	localparam logic [3:0] SCRIPT_LEN       = 4'd6;
	localparam logic [3:0] STYLE_LEN        = 4'd5;
	localparam logic [3:0] CLOSE_SCRIPT_LEN = 4'd9;
	localparam logic [3:0] CLOSE_STYLE_LEN  = 4'd8;

	localparam int Q_DEPTH = 8;
	localparam int Q_AW    = 3;
	localparam int Q_CW    = 4;

	localparam int DATA_W = 48;

	typedef struct packed {
		logic        has_char;
		logic [7:0]  ch;
		logic        last;
		logic [31:0] length;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	function automatic logic is_white(input logic [7:0] c);
		return (c == CH_SP) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic [7:0] comment_char(input logic [3:0] i);
		logic [7:0] r;
		unique case (i)
			4'd0:    r = CH_BANG;
			4'd1:    r = CH_DASH;
			4'd2:    r = CH_DASH;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] script_char(input logic [3:0] i);
		logic [7:0] r;
		unique case (i)
			4'd0:    r = 8'h73;
			4'd1:    r = 8'h63;
			4'd2:    r = 8'h72;
			4'd3:    r = 8'h69;
			4'd4:    r = 8'h70;
			4'd5:    r = 8'h74;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] style_char(input logic [3:0] i);
		logic [7:0] r;
		unique case (i)
			4'd0:    r = 8'h73;
			4'd1:    r = 8'h74;
			4'd2:    r = 8'h79;
			4'd3:    r = 8'h6C;
			4'd4:    r = 8'h65;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] close_script_char(input logic [3:0] i);
		logic [7:0] r;
		unique case (i)
			4'd0:    r = CH_LT;
			4'd1:    r = CH_SLASH;
			4'd2:    r = 8'h73;
			4'd3:    r = 8'h63;
			4'd4:    r = 8'h72;
			4'd5:    r = 8'h69;
			4'd6:    r = 8'h70;
			4'd7:    r = 8'h74;
			4'd8:    r = CH_GT;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] close_style_char(input logic [3:0] i);
		logic [7:0] r;
		unique case (i)
			4'd0:    r = CH_LT;
			4'd1:    r = CH_SLASH;
			4'd2:    r = 8'h73;
			4'd3:    r = 8'h74;
			4'd4:    r = 8'h79;
			4'd5:    r = 8'h6C;
			4'd6:    r = 8'h65;
			4'd7:    r = CH_GT;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

### src/hte_core.sv
`timescale 1ns / 1ps

module hte_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s1,
	input  logic [7:0]         byte_s1,
	input  logic               last_s1,
	output hte_pkg::push_t     push
);

	hte_pkg::mode_t mode_q, mode_nx;
	logic [3:0]     idx_q, idx_nx;
	logic [2:0]     cand_q, cand_nx;
	logic           after_q, after_nx;
	hte_pkg::sep_t  pend_q, pend_nx;
	logic [31:0]    cnt_q, cnt_nx;

	logic [7:0]     lc;
	logic [2:0]     keep;
	logic [3:0]     idx_inc;
	hte_pkg::mode_t tag_mode;
	logic [3:0]     tag_idx;
	logic [2:0]     tag_cand;
	logic           tag_after;
	hte_pkg::sep_t  tag_pend;
	logic [3:0]     cs_k;
	logic [3:0]     cy_k;
	logic [1:0]     n_emit;
	logic [7:0]     e0_ch, e1_ch;
	logic [32:0]    sum;
	logic [31:0]    cnt_sat;

	always_comb begin
		lc      = hte_pkg::to_lower(byte_s1);
		idx_inc = idx_q + 4'd1;

		keep = 3'b000;
		if (cand_q[0] && idx_q < hte_pkg::COMMENT_LEN && byte_s1 == hte_pkg::comment_char(idx_q))
			keep[0] = 1'b1;
		if (cand_q[1] && idx_q < hte_pkg::SCRIPT_LEN && lc == hte_pkg::script_char(idx_q))
			keep[1] = 1'b1;
		if (cand_q[2] && idx_q < hte_pkg::STYLE_LEN && lc == hte_pkg::style_char(idx_q))
			keep[2] = 1'b1;

		tag_mode  = hte_pkg::MODE_TAG;
		tag_idx   = 4'd0;
		tag_cand  = cand_q;
		tag_after = after_q;
		tag_pend  = pend_q;
		if (byte_s1 == hte_pkg::CH_LT) begin
			tag_mode = hte_pkg::MODE_OPEN;
			tag_cand = 3'b111;
		end else if (byte_s1 == hte_pkg::CH_GT) begin
			tag_mode = hte_pkg::MODE_TEXT;
			if (after_q) begin
				tag_pend  = hte_pkg::SEP_SPACE;
				tag_after = 1'b0;
			end
		end

		if (idx_q < hte_pkg::CLOSE_SCRIPT_LEN && lc == hte_pkg::close_script_char(idx_q))
			cs_k = idx_inc;
		else
			cs_k = (byte_s1 == hte_pkg::CH_LT) ? 4'd1 : 4'd0;
		if (idx_q < hte_pkg::CLOSE_STYLE_LEN && lc == hte_pkg::close_style_char(idx_q))
			cy_k = idx_inc;
		else
			cy_k = (byte_s1 == hte_pkg::CH_LT) ? 4'd1 : 4'd0;

		mode_nx  = mode_q;
		idx_nx   = idx_q;
		cand_nx  = cand_q;
		after_nx = after_q;
		pend_nx  = pend_q;
		n_emit   = 2'd0;
		e0_ch    = byte_s1;
		e1_ch    = byte_s1;

		unique case (mode_q)
			hte_pkg::MODE_TEXT: begin
				if (byte_s1 == hte_pkg::CH_LT) begin
					mode_nx = hte_pkg::MODE_OPEN;
					idx_nx  = 4'd0;
					cand_nx = 3'b111;
				end else if (hte_pkg::is_white(byte_s1)) begin
					if (after_q) begin
						pend_nx  = (byte_s1 == hte_pkg::CH_NL) ? hte_pkg::SEP_NEWLINE
							: hte_pkg::SEP_SPACE;
						after_nx = 1'b0;
					end
				end else begin
					if (pend_q == hte_pkg::SEP_SPACE) begin
						n_emit = 2'd2;
						e0_ch  = hte_pkg::CH_SP;
					end else if (pend_q == hte_pkg::SEP_NEWLINE) begin
						n_emit = 2'd2;
						e0_ch  = hte_pkg::CH_NL;
					end else begin
						n_emit = 2'd1;
					end
					pend_nx  = hte_pkg::SEP_NONE;
					after_nx = 1'b1;
				end
			end
			hte_pkg::MODE_OPEN: begin
				if (keep == 3'b000) begin
					mode_nx  = tag_mode;
					idx_nx   = tag_idx;
					cand_nx  = tag_cand;
					after_nx = tag_after;
					pend_nx  = tag_pend;
				end else begin
					cand_nx = keep;
					idx_nx  = idx_inc;
					if (keep[0] && idx_inc == hte_pkg::COMMENT_LEN) begin
						mode_nx = hte_pkg::MODE_COMMENT;
						idx_nx  = 4'd0;
					end else if (keep[1] && idx_inc == hte_pkg::SCRIPT_LEN) begin
						mode_nx = hte_pkg::MODE_SCRIPT;
						idx_nx  = 4'd0;
					end else if (keep[2] && idx_inc == hte_pkg::STYLE_LEN) begin
						mode_nx = hte_pkg::MODE_STYLE;
						idx_nx  = 4'd0;
					end
				end
			end
			hte_pkg::MODE_TAG: begin
				mode_nx  = tag_mode;
				idx_nx   = (tag_mode == hte_pkg::MODE_TAG) ? idx_q : tag_idx;
				cand_nx  = tag_cand;
				after_nx = tag_after;
				pend_nx  = tag_pend;
			end
			hte_pkg::MODE_COMMENT: begin
				if (byte_s1 == hte_pkg::CH_DASH) begin
					idx_nx = (idx_q[1:0] < 2'd2) ? {2'b00, idx_q[1:0] + 2'd1} : 4'd2;
				end else if (byte_s1 == hte_pkg::CH_GT && idx_q[1:0] == 2'd2) begin
					mode_nx = hte_pkg::MODE_TEXT;
					idx_nx  = 4'd0;
				end else begin
					idx_nx = 4'd0;
				end
			end
			hte_pkg::MODE_SCRIPT: begin
				if (cs_k == hte_pkg::CLOSE_SCRIPT_LEN) begin
					mode_nx = hte_pkg::MODE_TEXT;
					idx_nx  = 4'd0;
				end else begin
					idx_nx = cs_k;
				end
			end
			hte_pkg::MODE_STYLE: begin
				if (cy_k == hte_pkg::CLOSE_STYLE_LEN) begin
					mode_nx = hte_pkg::MODE_TEXT;
					idx_nx  = 4'd0;
				end else begin
					idx_nx = cy_k;
				end
			end
			default: begin
				mode_nx = hte_pkg::MODE_TEXT;
				idx_nx  = 4'd0;
			end
		endcase

		sum     = {1'b0, cnt_q} + {31'd0, n_emit};
		cnt_sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		cnt_nx  = cnt_sat;

		push.n            = n_emit;
		push.r0.has_char  = 1'b1;
		push.r0.ch        = e0_ch;
		push.r0.last      = 1'b0;
		push.r0.length    = 32'd0;
		push.r1.has_char  = 1'b1;
		push.r1.ch        = e1_ch;
		push.r1.last      = 1'b0;
		push.r1.length    = 32'd0;

		if (last_s1) begin
			unique case (n_emit)
				2'd0: begin
					push.n           = 2'd1;
					push.r0.has_char = 1'b0;
					push.r0.ch       = 8'd0;
					push.r0.last     = 1'b1;
					push.r0.length   = cnt_sat;
				end
				2'd1: begin
					push.r0.last   = 1'b1;
					push.r0.length = cnt_sat;
				end
				default: begin
					push.r1.last   = 1'b1;
					push.r1.length = cnt_sat;
				end
			endcase
			mode_nx  = hte_pkg::MODE_TEXT;
			idx_nx   = 4'd0;
			cand_nx  = 3'b111;
			after_nx = 1'b0;
			pend_nx  = hte_pkg::SEP_NONE;
			cnt_nx   = 32'd0;
		end

		if (!valid_s1)
			push.n = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= hte_pkg::MODE_TEXT;
			idx_q   <= 4'd0;
			cand_q  <= 3'b111;
			after_q <= 1'b0;
			pend_q  <= hte_pkg::SEP_NONE;
			cnt_q   <= 32'd0;
		end else if (valid_s1) begin
			mode_q  <= mode_nx;
			idx_q   <= idx_nx;
			cand_q  <= cand_nx;
			after_q <= after_nx;
			pend_q  <= pend_nx;
			cnt_q   <= cnt_nx;
		end
	end

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 |=> mode_q == hte_pkg::MODE_TEXT && cnt_q == 32'd0
			&& pend_q == hte_pkg::SEP_NONE)
		else $error("state not cleared after final byte");

	a_pair_is_sep: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> (push.r0.ch == hte_pkg::CH_SP || push.r0.ch == hte_pkg::CH_NL)
			&& !push.r0.last)
		else $error("two-result transaction without leading separator");

endmodule

### src/hte_outq.sv
`timescale 1ns / 1ps

module hte_outq (
	input  logic                     clk,
	input  logic                     arst_n,
	input  hte_pkg::push_t           push,
	output logic [hte_pkg::Q_CW-1:0] count,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output hte_pkg::res_t            head
);

	hte_pkg::res_t             mem_q [hte_pkg::Q_DEPTH];
	logic [hte_pkg::Q_AW-1:0]  wp_q, rp_q;
	logic [hte_pkg::Q_CW-1:0]  cnt_q;
	logic                      pop;

	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = cnt_q != '0;
	assign head     = mem_q[rp_q];
	assign count    = cnt_q;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem_q[wp_q] <= push.r0;
		if (push.n == 2'd2)
			mem_q[wp_q + hte_pkg::Q_AW'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + hte_pkg::Q_AW'(push.n);
			if (pop)
				rp_q <= rp_q + hte_pkg::Q_AW'(1);
			cnt_q <= cnt_q + hte_pkg::Q_CW'(push.n) - hte_pkg::Q_CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= hte_pkg::Q_CW'(hte_pkg::Q_DEPTH))
		else $error("output queue overflow");

	a_room_for_push: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> {1'b0, cnt_q} + {{(hte_pkg::Q_CW - 1){1'b0}}, push.n}
			<= (hte_pkg::Q_CW + 1)'(hte_pkg::Q_DEPTH))
		else $error("push into full output queue");

endmodule

### src/html_text_extractor_unit.sv
`timescale 1ns / 1ps
// Path: an accepted byte is registered into the s1 stage, reduced by the core and written
// to the output queue; once the queue is non-empty, m_tvalid shows its first result.
// Throughput: one byte per cycle while s_tready is high; s_tready drops unless the queue
// has room for two results from the registered byte and two from the incoming one. A byte
// that releases a held separator yields two results, absorbed by the 8-entry queue.
// Reset: arst_n clears the stream state, emitted count and queue pointers at once.

module html_text_extractor_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,  // [7:0] in_byte
	input  logic                       s_tlast,  // in_last
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [hte_pkg::DATA_W-1:0] m_tdata,  // [0] has_char, [8:1] out_char,
	                                             // [40:9] out_length, [47:41] zero
	output logic                       m_tlast   // out_last
);

	logic                      valid_s1;
	logic [7:0]                byte_s1;
	logic                      last_s1;
	hte_pkg::push_t            push;
	hte_pkg::res_t             head;
	logic [hte_pkg::Q_CW-1:0]  q_count;
	logic [hte_pkg::Q_CW:0]    q_need;

	// leave room for the worst case of two results from the registered byte
	assign q_need   = {1'b0, q_count} + {{(hte_pkg::Q_CW - 1){1'b0}}, valid_s1, 1'b0};
	assign s_tready = q_need <= (hte_pkg::Q_CW + 1)'(hte_pkg::Q_DEPTH - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= s_tvalid && s_tready;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	hte_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.last_s1  (last_s1),
		.push     (push)
	);

	hte_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.count    (q_count),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.head     (head)
	);

	assign m_tdata = {7'd0, head.length, head.ch, head.has_char};
	assign m_tlast = head.last;

endmodule

### test/html_text_extractor_unit_test.sv
`timescale 1ns / 1ps

module html_text_extractor_unit_test;

	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 10;

	typedef enum int {RX_ALWAYS, RX_RANDOM, RX_BURSTY, RX_HEAVY} rx_style_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [hte_pkg::DATA_W-1:0] m_tdata;
	logic m_tlast;

	html_text_extractor_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always #10 clk = ~clk;

	string kw_comment = "!--";
	string kw_script = "script";
	string kw_style = "style";
	string end_script = "</script>";
	string end_style = "</style>";

	// predicted state of the extractor
	hte_pkg::mode_t text_mode;
	logic [3:0] match_pos;
	logic [2:0] open_prefixes;
	logic after_word;
	hte_pkg::sep_t held_sep;
	logic [31:0] text_count;

	hte_pkg::res_t expected_text[$];
	logic [7:0] html_doc[$];

	rx_style_t rx_style = RX_ALWAYS;
	bit send_gaps = 1'b0;
	int burst_left = 0;
	int rx_left = 0;
	bit rx_phase = 1'b1;
	int idle_cycles = 0;
	int mismatches = 0;
	int bytes_sent = 0;
	int documents = 0;
	int results_checked = 0;
	int paired_results = 0;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	function automatic logic blank_byte(input logic [7:0] c);
		return c == hte_pkg::CH_SP || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic void clear_prediction();
		text_mode = hte_pkg::MODE_TEXT;
		match_pos = '0;
		open_prefixes = 3'b111;
		after_word = 1'b0;
		held_sep = hte_pkg::SEP_NONE;
		text_count = '0;
	endfunction

	function automatic void emit_text(input logic [7:0] c);
		hte_pkg::res_t r;
		r.has_char = 1'b1;
		r.ch = c;
		r.last = 1'b0;
		r.length = '0;
		expected_text.push_back(r);
		if (text_count != 32'hFFFF_FFFF)
			text_count++;
	endfunction

	function automatic void start_prefix();
		text_mode = hte_pkg::MODE_OPEN;
		match_pos = '0;
		open_prefixes = 3'b111;
	endfunction

	function automatic void tag_step(input logic [7:0] c);
		if (c == hte_pkg::CH_LT) begin
			start_prefix();
		end else if (c == hte_pkg::CH_GT) begin
			text_mode = hte_pkg::MODE_TEXT;
			match_pos = '0;
			if (after_word) begin
				held_sep = hte_pkg::SEP_SPACE;
				after_word = 1'b0;
			end
		end
	endfunction

	function automatic logic [3:0] close_advance(input string pat, input logic [3:0] k,
			input logic [7:0] c);
		if (k < pat.len() && fold_case(c) == pat[k])
			return k + 4'd1;
		return (c == hte_pkg::CH_LT) ? 4'd1 : 4'd0;
	endfunction

	function automatic void prefix_step(input logic [7:0] c);
		logic [2:0] keep;
		logic [7:0] lc;
		lc = fold_case(c);
		keep = '0;
		if (open_prefixes[0] && match_pos < 3 && c == kw_comment[match_pos])
			keep[0] = 1'b1;
		if (open_prefixes[1] && match_pos < 6 && lc == kw_script[match_pos])
			keep[1] = 1'b1;
		if (open_prefixes[2] && match_pos < 5 && lc == kw_style[match_pos])
			keep[2] = 1'b1;
		if (keep == '0) begin
			text_mode = hte_pkg::MODE_TAG;
			match_pos = '0;
			tag_step(c);
		end else begin
			match_pos = match_pos + 4'd1;
			open_prefixes = keep;
			if (keep[0] && match_pos == 4'd3) begin
				text_mode = hte_pkg::MODE_COMMENT;
				match_pos = '0;
			end else if (keep[1] && match_pos == 4'd6) begin
				text_mode = hte_pkg::MODE_SCRIPT;
				match_pos = '0;
			end else if (keep[2] && match_pos == 4'd5) begin
				text_mode = hte_pkg::MODE_STYLE;
				match_pos = '0;
			end
		end
	endfunction

	function automatic void extract_text(input logic [7:0] c, input logic last);
		int n_before;
		logic [3:0] k;
		hte_pkg::res_t r;
		n_before = expected_text.size();
		case (text_mode)
			hte_pkg::MODE_TEXT: begin
				if (c == hte_pkg::CH_LT) begin
					start_prefix();
				end else if (blank_byte(c)) begin
					if (after_word) begin
						held_sep = (c == hte_pkg::CH_NL) ? hte_pkg::SEP_NEWLINE
							: hte_pkg::SEP_SPACE;
						after_word = 1'b0;
					end
				end else begin
					if (held_sep == hte_pkg::SEP_SPACE)
						emit_text(hte_pkg::CH_SP);
					else if (held_sep == hte_pkg::SEP_NEWLINE)
						emit_text(hte_pkg::CH_NL);
					emit_text(c);
					held_sep = hte_pkg::SEP_NONE;
					after_word = 1'b1;
				end
			end
			hte_pkg::MODE_OPEN: prefix_step(c);
			hte_pkg::MODE_TAG: tag_step(c);
			hte_pkg::MODE_COMMENT: begin
				if (c == hte_pkg::CH_DASH) begin
					match_pos = (match_pos < 2) ? match_pos + 4'd1 : 4'd2;
				end else if (c == hte_pkg::CH_GT && match_pos == 4'd2) begin
					text_mode = hte_pkg::MODE_TEXT;
					match_pos = '0;
				end else begin
					match_pos = '0;
				end
			end
			hte_pkg::MODE_SCRIPT: begin
				k = close_advance(end_script, match_pos, c);
				if (k == 4'd9) begin
					text_mode = hte_pkg::MODE_TEXT;
					k = '0;
				end
				match_pos = k;
			end
			hte_pkg::MODE_STYLE: begin
				k = close_advance(end_style, match_pos, c);
				if (k == 4'd8) begin
					text_mode = hte_pkg::MODE_TEXT;
					k = '0;
				end
				match_pos = k;
			end
			default: begin
				text_mode = hte_pkg::MODE_TEXT;
				match_pos = '0;
			end
		endcase
		if (expected_text.size() - n_before == 2)
			paired_results++;
		if (last) begin
			if (expected_text.size() == n_before) begin
				r = '0;
				expected_text.push_back(r);
			end
			r = expected_text[expected_text.size() - 1];
			r.last = 1'b1;
			r.length = text_count;
			expected_text[expected_text.size() - 1] = r;
			clear_prediction();
		end
	endfunction

	task automatic idle_for(input int n);
		@(negedge clk) s_tvalid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic hold_off();
		@(negedge clk) s_tvalid <= 1'b0;
	endtask

	task automatic send_byte(input logic [7:0] c, input logic last);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		extract_text(c, last);
		bytes_sent++;
		if (last)
			documents++;
		if (send_gaps) begin
			if (burst_left == 0) begin
				idle_for($urandom_range(1, 6));
				burst_left = $urandom_range(1, 16);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic drain_results();
		hold_off();
		wait (expected_text.size() == 0);
	endtask

	task automatic send_doc();
		for (int i = 0; i < html_doc.size(); i++)
			send_byte(html_doc[i], i == html_doc.size() - 1);
		html_doc.delete();
	endtask

	function automatic void push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			html_doc.push_back(s[i]);
	endfunction

	function automatic void push_keyword(input string w);
		logic [7:0] c;
		for (int i = 0; i < w.len(); i++) begin
			c = w[i];
			if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 2) == 0)
				c = c - 8'd32;
			html_doc.push_back(c);
		end
	endfunction

	function automatic logic [7:0] word_byte();
		logic [7:0] c;
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) begin
			c = 8'($urandom_range(8'h21, 8'h7E));
			if (c == hte_pkg::CH_LT)
				c = 8'h61;
		end else if (r < 8) begin
			c = 8'($urandom_range(8'h80, 8'hFF));
		end else if (r == 8) begin
			c = 8'($urandom_range(8'h00, 8'h08));
		end else begin
			c = 8'($urandom_range(8'h0E, 8'h1F));
		end
		return c;
	endfunction

	function automatic logic [7:0] blank_pick();
		int k;
		k = $urandom_range(0, 5);
		return (k == 0) ? hte_pkg::CH_SP : 8'h08 + k[7:0];
	endfunction

	function automatic void push_name();
		repeat ($urandom_range(1, 4))
			html_doc.push_back(8'($urandom_range(8'h61, 8'h7A)));
	endfunction

	function automatic void push_element_body(input string pat);
		int r;
		repeat ($urandom_range(0, 10)) begin
			r = $urandom_range(0, pat.len() + 2);
			if (r < pat.len())
				html_doc.push_back((pat[r] >= 8'h61 && $urandom_range(0, 1)) ?
					pat[r] - 8'd32 : pat[r]);
			else
				html_doc.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	function automatic void push_element(input string name, input string pat);
		html_doc.push_back(hte_pkg::CH_LT);
		push_keyword(name);
		case ($urandom_range(0, 3))
			0: html_doc.push_back(8'h78);
			1: begin
				html_doc.push_back(hte_pkg::CH_SP);
				push_name();
			end
			default: ;
		endcase
		html_doc.push_back(hte_pkg::CH_GT);
		push_element_body(pat);
		if ($urandom_range(0, 7) != 0) begin
			html_doc.push_back(hte_pkg::CH_LT);
			html_doc.push_back(hte_pkg::CH_SLASH);
			push_keyword(name);
			html_doc.push_back(hte_pkg::CH_GT);
		end
	endfunction

	function automatic void build_markup_document();
		repeat ($urandom_range(1, 8)) begin
			case ($urandom_range(0, 9))
				0, 1, 2: repeat ($urandom_range(1, 6)) html_doc.push_back(word_byte());
				3: repeat ($urandom_range(1, 3)) html_doc.push_back(blank_pick());
				4, 5: begin
					html_doc.push_back(hte_pkg::CH_LT);
					case ($urandom_range(0, 5))
						0: begin
							html_doc.push_back(hte_pkg::CH_SLASH);
							push_name();
						end
						1: begin
							if ($urandom_range(0, 1))
								push_keyword("scrip");
							else
								push_keyword("styl");
							html_doc.push_back(8'h71);
						end
						2: push_str("!-x");
						3: begin
							html_doc.push_back(hte_pkg::CH_BANG);
							push_name();
						end
						default: push_name();
					endcase
					if ($urandom_range(0, 1)) begin
						html_doc.push_back(hte_pkg::CH_SP);
						push_name();
					end
					if ($urandom_range(0, 15) != 0)
						html_doc.push_back(hte_pkg::CH_GT);
				end
				6: begin
					push_str("<!--");
					push_element_body("-->a< ");
					if ($urandom_range(0, 7) != 0)
						push_str("-->");
				end
				7: push_element("script", "</script>x");
				8: push_element("style", "</style>x");
				default: html_doc.push_back(8'($urandom_range(0, 255)));
			endcase
		end
	endfunction

	task automatic test_directed_cases();
		rx_style = RX_RANDOM;
		send_gaps = 1'b1;
		// leading blank, newline held through a script with loose prefix, trailing blank
		push_str("\tA\n<SCRIPTx<</script>");
		html_doc.push_back(8'hFF);
		html_doc.push_back(hte_pkg::CH_SP);
		send_doc();
		// failed prefix restarts on '<', then an unclosed comment
		push_str("<s<!--->");
		html_doc.push_back(8'h00);
		send_doc();
		push_str("<sTyLe>");
		send_doc();
		push_str("x");
		send_doc();
		drain_results();
	endtask

	task automatic test_markup_documents(input int n);
		int start;
		start = bytes_sent;
		rx_style = RX_BURSTY;
		while (bytes_sent - start < n) begin
			send_gaps = ($urandom_range(0, 3) != 0);
			build_markup_document();
			send_doc();
			if ($urandom_range(0, 5) == 0)
				drain_results();
		end
		hold_off();
	endtask

	task automatic test_noise_bytes(input int n);
		int r;
		logic [7:0] c;
		rx_style = RX_RANDOM;
		send_gaps = 1'b1;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 7);
			case (r)
				0: c = hte_pkg::CH_LT;
				1: c = hte_pkg::CH_GT;
				2: c = hte_pkg::CH_DASH;
				3: c = 8'($urandom_range(8'h61, 8'h7A));
				default: c = 8'($urandom_range(0, 255));
			endcase
			send_byte(c, i == n - 1 || $urandom_range(0, 29) == 0);
		end
		hold_off();
	endtask

	task automatic test_full_rate(input int n);
		int start;
		start = bytes_sent;
		send_gaps = 1'b0;
		rx_style = RX_ALWAYS;
		while (bytes_sent - start < n) begin
			if (bytes_sent - start > n / 2)
				rx_style = RX_HEAVY;
			build_markup_document();
			send_doc();
		end
		hold_off();
	endtask

	always @(negedge clk) begin
		case (rx_style)
			RX_ALWAYS: m_tready <= 1'b1;
			RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
			RX_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
			default: begin
				if (rx_left == 0) begin
					rx_phase = !rx_phase;
					rx_left = rx_phase ? $urandom_range(1, 10) : $urandom_range(1, 12);
				end else begin
					rx_left--;
				end
				m_tready <= rx_phase;
			end
		endcase
	end

	always @(posedge clk) begin
		hte_pkg::res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_checked++;
			if (expected_text.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result tdata=%h tlast=%b", $realtime, m_tdata,
						m_tlast);
			end else begin
				want = expected_text.pop_front();
				if (m_tdata[0] !== want.has_char || m_tdata[8:1] !== want.ch
						|| m_tdata[40:9] !== want.length || m_tdata[47:41] !== 7'd0
						|| m_tlast !== want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("%0t: result mismatch: expected has_char=%b char=%h last=%b",
							$realtime, want.has_char, want.ch, want.last);
						$display(" length=%0d, got has_char=%b char=%h last=%b length=%0d pad=%h",
							want.length, m_tdata[0], m_tdata[8:1], m_tlast, m_tdata[40:9],
							m_tdata[47:41]);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("html_text_extractor_unit_test failed");
			$finish;
		end
	end

	initial begin
		clear_prediction();
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		test_directed_cases();
		test_markup_documents(350);
		test_noise_bytes(120);
		test_full_rate(130);
		hold_off();
		wait (expected_text.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d bytes in %0d documents; checked %0d results,", bytes_sent,
			documents, results_checked);
		$display("%0d bytes released a held separator; %0d mismatches", paired_results,
			mismatches);
		if (mismatches == 0)
			$display("html_text_extractor_unit_test passed");
		else
			$display("html_text_extractor_unit_test failed");
		$finish;
	end

endmodule

### html_text_extractor_unit.f
src/hte_pkg.sv
src/hte_core.sv
src/hte_outq.sv
src/html_text_extractor_unit.sv
test/html_text_extractor_unit_test.sv
